### src/sssc_pkg.sv
package sssc_pkg;

   // Default number of tracked sensors
   localparam int SENSOR_COUNT_DEF = 2;

   localparam int SENSOR_W = 4;
   localparam int WORD_W   = 32;
   localparam int FAIL_W   = 9;
   localparam int LIMIT_W  = 8;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SENSOR = 3'd1,
      ST_BUS_FAIL   = 3'd2,
      ST_SEQ_GAP    = 3'd3,
      ST_TIME_BACK  = 3'd4
   } status_type;

   // Input beat, last field in the lowest bits
   typedef struct packed {
      logic [FAIL_W-1:0]   bus_fail_count;
      logic [WORD_W-1:0]   raw_word;
      logic [WORD_W-1:0]   time_in;
      logic [WORD_W-1:0]   seq_in;
      logic [SENSOR_W-1:0] sensor_num;
   } req_item_type;

   // Result beat, last field in the lowest bits
   typedef struct packed {
      logic [WORD_W-1:0]        time_regress_total;
      logic [WORD_W-1:0]        seq_errors_total;
      logic [WORD_W-1:0]        failed_total;
      logic [WORD_W-1:0]        retries_total;
      logic [WORD_W-1:0]        attempts_total;
      logic signed [WORD_W-1:0] sample_value;
      logic [WORD_W-1:0]        time_out;
      logic [WORD_W-1:0]        seq_out;
      logic [SENSOR_W-1:0]      sensor_out;
      status_type               status;
   } rsp_item_type;

   localparam int REQ_BITS   = $bits(req_item_type);
   localparam int RSP_BITS   = $bits(rsp_item_type);
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Per-sensor check outcome, already qualified by the seen flag
   typedef struct packed {
      logic seq_gap;
      logic time_back;
   } check_type;

endpackage

### src/sensor_sample_sequence_checker.sv
// Sensor read sequence checker. Each request beat is one sensor read; each
// produces exactly one response beat with a status, the echoed read (zeroed
// unless the status is ok) and five wrapping 32-bit statistics totals as they
// stand after that read. A read passes through an input register and then a
// result register on its way to the response, and one read is accepted every
// cycle while the response side keeps up. Per-sensor
// sequence and timestamp state lives in flip-flops; reset clears the seen
// flags, so the block is ready right after reset. retry_limit is written
// through the csr port and should only change while no read is in flight.
module sensor_sample_sequence_checker
   import sssc_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [LIMIT_W-1:0]     csr_wdata,   // retry_limit

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sensor_num, seq_in, time_in, raw_word, bus_fail_count, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, sensor_out, seq_out, time_out, sample_value, attempts_total,
   // retries_total, failed_total, seq_errors_total, time_regress_total, pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [LIMIT_W-1:0] retry_limit_ff;
   logic               in_valid_ff;
   logic               in_valid_in;
   req_item_type       in_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               advance;

   status_type          status_ff,  status_in;
   logic [SENSOR_W-1:0] sensor_ff;
   logic [WORD_W-1:0]   seq_ff,     seq_in;
   logic [WORD_W-1:0]   time_ff,    time_in;
   logic [WORD_W-1:0]   value_ff,   value_in;

   logic [WORD_W-1:0] attempts_ff, attempts_in;
   logic [WORD_W-1:0] retries_ff,  retries_in;
   logic [WORD_W-1:0] failed_ff,   failed_in;
   logic [WORD_W-1:0] seq_err_ff,  seq_err_in;
   logic [WORD_W-1:0] regress_ff,  regress_in;

   logic              sensor_ok;
   logic [FAIL_W-1:0] limit;
   logic              bus_ok;
   check_type         check;
   rsp_item_type      rsp_item;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= '0;
      end else if (csr_we) begin
         retry_limit_ff <= csr_wdata;
      end
   end

   // Handshake: input stage moves forward when the result register frees up
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item_type'(req_tdata[REQ_BITS-1:0]);
      end
   end

   // Sensor range and bus attempt budget
   assign sensor_ok = ({1'b0, in_item_ff.sensor_num} < (SENSOR_W + 1)'(SENSOR_COUNT));
   assign limit     = {1'b0, retry_limit_ff} + FAIL_W'(1);
   assign bus_ok    = in_item_ff.bus_fail_count < limit;

   sssc_table #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_sssc_table (
      .clock      (clock),
      .reset      (reset),
      .sensor_num (in_item_ff.sensor_num),
      .seq_in     (in_item_ff.seq_in),
      .time_in    (in_item_ff.time_in),
      .update     (advance && sensor_ok && bus_ok),
      .check      (check)
   );

   // Status, echoed fields and next statistics
   always_comb begin
      status_in   = ST_OK;
      seq_in      = '0;
      time_in     = '0;
      value_in    = '0;
      attempts_in = attempts_ff;
      retries_in  = retries_ff;
      failed_in   = failed_ff;
      seq_err_in  = seq_err_ff;
      regress_in  = regress_ff;
      if (!sensor_ok) begin
         status_in = ST_BAD_SENSOR;
      end else if (!bus_ok) begin
         status_in   = ST_BUS_FAIL;
         attempts_in = attempts_ff + WORD_W'(limit);
         retries_in  = retries_ff + WORD_W'(retry_limit_ff);
         failed_in   = failed_ff + WORD_W'(1);
      end else begin
         attempts_in = attempts_ff + WORD_W'(in_item_ff.bus_fail_count) + WORD_W'(1);
         retries_in  = retries_ff + WORD_W'(in_item_ff.bus_fail_count);
         if (check.seq_gap) begin
            seq_err_in = seq_err_ff + WORD_W'(1);
         end
         if (check.time_back) begin
            regress_in = regress_ff + WORD_W'(1);
         end
         if (check.seq_gap) begin
            status_in = ST_SEQ_GAP;
         end else if (check.time_back) begin
            status_in = ST_TIME_BACK;
         end else begin
            seq_in   = in_item_ff.seq_in;
            time_in  = in_item_ff.time_in;
            value_in = in_item_ff.raw_word;
         end
      end
   end

   // Statistics change only when a result is loaded, so they double as output
   always_ff @(posedge clock) begin
      if (reset) begin
         attempts_ff <= '0;
         retries_ff  <= '0;
         failed_ff   <= '0;
         seq_err_ff  <= '0;
         regress_ff  <= '0;
      end else if (advance) begin
         attempts_ff <= attempts_in;
         retries_ff  <= retries_in;
         failed_ff   <= failed_in;
         seq_err_ff  <= seq_err_in;
         regress_ff  <= regress_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         sensor_ff <= in_item_ff.sensor_num;
         seq_ff    <= seq_in;
         time_ff   <= time_in;
         value_ff  <= value_in;
      end
   end

   always_comb begin
      rsp_item.status             = status_ff;
      rsp_item.sensor_out         = sensor_ff;
      rsp_item.seq_out            = seq_ff;
      rsp_item.time_out           = time_ff;
      rsp_item.sample_value       = value_ff;
      rsp_item.attempts_total     = attempts_ff;
      rsp_item.retries_total      = retries_ff;
      rsp_item.failed_total       = failed_ff;
      rsp_item.seq_errors_total   = seq_err_ff;
      rsp_item.time_regress_total = regress_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_BITS)'(0), rsp_item};

endmodule

### src/sssc_table.sv
module sssc_table
   import sssc_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SENSOR_W-1:0] sensor_num,
   input  logic [WORD_W-1:0]   seq_in,
   input  logic [WORD_W-1:0]   time_in,
   input  logic                update,
   output check_type           check
);

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   logic              seen_ff      [SENSOR_COUNT];
   logic [WORD_W-1:0] last_seq_ff  [SENSOR_COUNT];
   logic [WORD_W-1:0] last_time_ff [SENSOR_COUNT];
   logic [IDX_W-1:0]  idx;

   assign idx = sensor_num[IDX_W-1:0];

   // Continuity and regression checks against the stored entry
   always_comb begin
      check.seq_gap   = seen_ff[idx] && (seq_in != (last_seq_ff[idx] + WORD_W'(1)));
      check.time_back = seen_ff[idx] && (time_in < last_time_ff[idx]);
   end

   // Seen flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            seen_ff[i] <= 1'b0;
         end
      end else if (update) begin
         seen_ff[idx] <= 1'b1;
      end
   end

   // Stored sequence always resyncs; a regressed timestamp is dropped
   always_ff @(posedge clock) begin
      if (update) begin
         last_seq_ff[idx] <= seq_in;
         if (!check.time_back) begin
            last_time_ff[idx] <= time_in;
         end
      end
   end

endmodule

### src/sssc_checker.sv
module sssc_checker
   import sssc_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   status_type          status;
   logic [SENSOR_W-1:0] sensor;
   logic [3*WORD_W-1:0] echo;
   logic                out_of_range;

   assign status       = status_type'(rsp_tdata[2:0]);
   assign sensor       = rsp_tdata[6:3];
   assign echo         = rsp_tdata[3*WORD_W+6:7];
   assign out_of_range = ({1'b0, sensor} >= (SENSOR_W + 1)'(SENSOR_COUNT));

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Input side is open right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready right after reset");

   // Any error status zeroes the echoed read
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != ST_OK) |-> (echo == '0))
      else $error("echoed fields nonzero on error status");

   // Invalid-sensor status exactly for out-of-range sensor numbers
   a_bad_sensor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((status == ST_BAD_SENSOR) == out_of_range))
      else $error("invalid-sensor status mismatch");

endmodule

bind sensor_sample_sequence_checker sssc_checker #(
   .SENSOR_COUNT (SENSOR_COUNT)
) u_sssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
